FILE: rtl/wtzs_pkg.sv
// ----------------------------------------------------------------------------
// wtzs_pkg
// Shared constants and the control/status bundles of the windowed threshold
// zero-suppression block.
// ----------------------------------------------------------------------------
package wtzs_pkg;

  localparam int CODE_W      = 14;
  localparam int POS_W       = 14;
  localparam int HALF_WINDOW = 20;
  localparam int FRAME_DEPTH = 16384;

  // Samples held back so that the hits after them can be seen.
  localparam int LINE_DEPTH  = HALF_WINDOW - 1;
  // Line length including the slot for the newest sample.
  localparam int LINE_LEN    = HALF_WINDOW;
  localparam int FILL_W      = $clog2(LINE_LEN + 1);
  localparam int NO_HIT      = 2 * HALF_WINDOW;
  localparam int SLH_W       = $clog2(NO_HIT + 1);
  localparam int KEEP_W      = SLH_W + 1;

  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_DEPTH - 1);

  localparam int IN_TDATA_W  = ((CODE_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((CODE_W + POS_W + 7) / 8) * 8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;         // input transaction accepted this cycle
    logic flush_emit;   // emit the oldest waiting sample during a flush
    logic flush_done;   // flush is over, clear the hit history
  } wtzs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic end_now;      // the offered sample closes the frame
    logic out_free;     // output register can take a result this cycle
    logic flush_keep;   // oldest waiting sample lies in a hit window
    logic flush_last;   // it is also the last sample to be kept
  } wtzs_stat_t;

endpackage

FILE: rtl/wtzs_ctrl.sv
// ----------------------------------------------------------------------------
// wtzs_ctrl
// Controller: streams samples in, then drains the lookahead line at frame end.
// ----------------------------------------------------------------------------
module wtzs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  wtzs_pkg::wtzs_stat_t stat,
  output wtzs_pkg::wtzs_cmd_t  cmd
);
  import wtzs_pkg::*;

  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_FLUSH = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    in_ready       = (state == ST_RUN) && stat.out_free;
    cmd.take       = in_valid && in_ready;
    cmd.flush_emit = 1'b0;
    cmd.flush_done = 1'b0;
    state_next     = state;
    case (state)
      ST_RUN: begin
        if (cmd.take && stat.end_now) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        // Kept samples form a prefix of the line, so the first sample that
        // is not kept ends the flush.
        if (!stat.flush_keep) begin
          cmd.flush_done = 1'b1;
          state_next     = ST_RUN;
        end else if (stat.out_free) begin
          cmd.flush_emit = 1'b1;
          if (stat.flush_last) begin
            cmd.flush_done = 1'b1;
            state_next     = ST_RUN;
          end
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/wtzs_datapath.sv
// ----------------------------------------------------------------------------
// wtzs_datapath
// Lookahead line, hit distance tracking, frame position and output register.
// ----------------------------------------------------------------------------
module wtzs_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic signed [wtzs_pkg::CODE_W-1:0]   cfg_wdata,
  input  logic signed [wtzs_pkg::CODE_W-1:0]   in_sample,
  input  logic                                 in_last,
  input  wtzs_pkg::wtzs_cmd_t                   cmd,
  output wtzs_pkg::wtzs_stat_t                  stat,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [wtzs_pkg::CODE_W-1:0]   out_sample,
  output logic        [wtzs_pkg::POS_W-1:0]    out_pos,
  output logic                                 out_last
);
  import wtzs_pkg::*;

  logic signed [CODE_W-1:0] threshold;
  logic signed [CODE_W-1:0] line [LINE_LEN];
  logic [FILL_W-1:0]        fill;
  logic [SLH_W-1:0]         slh;
  logic [SLH_W-1:0]         slh_next;
  logic [POS_W-1:0]         frame_index;
  logic [FILL_W-1:0]        remain;
  logic [POS_W-1:0]         flush_pos;
  logic                     hit;
  logic                     line_full;
  logic                     run_emit;

  assign hit       = in_sample <= threshold;
  assign line_full = fill == FILL_W'(LINE_DEPTH);

  always_comb begin
    if (hit) begin
      slh_next = '0;
    end else if (slh < SLH_W'(NO_HIT)) begin
      slh_next = slh + SLH_W'(1);
    end else begin
      slh_next = slh;
    end
  end

  assign stat.end_now    = in_last || (frame_index == POS_LAST);
  assign stat.out_free   = !out_valid || out_ready;
  // Oldest waiting sample has age remain-1; it is kept when the latest hit
  // is no farther back than age plus the half window.
  assign stat.flush_keep = KEEP_W'(slh) <=
                           KEEP_W'(remain) + KEEP_W'(HALF_WINDOW - 1);
  assign stat.flush_last = (remain == FILL_W'(1)) ||
                           (KEEP_W'(slh) > KEEP_W'(remain) + KEEP_W'(HALF_WINDOW - 2));

  assign run_emit = cmd.take && !stat.end_now && line_full &&
                    (slh_next <= SLH_W'(LINE_DEPTH + HALF_WINDOW));

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= -(CODE_W'(1) <<< (CODE_W - 1));
    end else if (cfg_we) begin
      threshold <= cfg_wdata;
    end
  end

  // Lookahead line: shifts toward index 0 as samples leave.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      if (!stat.end_now && line_full) begin
        for (int i = 0; i < LINE_DEPTH - 1; i++) begin
          line[i] <= line[i+1];
        end
        line[LINE_DEPTH-1] <= in_sample;
      end else begin
        for (int i = 0; i < LINE_LEN; i++) begin
          if (fill == FILL_W'(i)) begin
            line[i] <= in_sample;
          end
        end
      end
    end else if (cmd.flush_emit) begin
      for (int i = 0; i < LINE_LEN - 1; i++) begin
        line[i] <= line[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill        <= '0;
      slh         <= SLH_W'(NO_HIT);
      frame_index <= '0;
      remain      <= '0;
    end else begin
      if (cmd.take) begin
        slh <= slh_next;
        if (stat.end_now) begin
          remain      <= fill + FILL_W'(1);
          fill        <= '0;
          frame_index <= '0;
        end else begin
          if (!line_full) begin
            fill <= fill + FILL_W'(1);
          end
          frame_index <= frame_index + POS_W'(1);
        end
      end
      if (cmd.flush_done) begin
        slh    <= SLH_W'(NO_HIT);
        remain <= '0;
      end else if (cmd.flush_emit) begin
        remain <= remain - FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && stat.end_now) begin
      flush_pos <= frame_index - POS_W'(fill);
    end else if (cmd.flush_emit) begin
      flush_pos <= flush_pos + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (run_emit || cmd.flush_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (run_emit) begin
      out_sample <= line[0];
      out_pos    <= frame_index - POS_W'(LINE_DEPTH);
      out_last   <= 1'b1;
    end else if (cmd.flush_emit) begin
      out_sample <= line[0];
      out_pos    <= flush_pos;
      out_last   <= stat.flush_last;
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(LINE_DEPTH))
    else $error("lookahead fill count beyond line depth");

  a_emit_needs_slot: assert property (@(posedge clk) disable iff (rst)
    (run_emit || cmd.flush_emit) |-> stat.out_free)
    else $error("result loaded while output register still occupied");

  a_flush_has_data: assert property (@(posedge clk) disable iff (rst)
    cmd.flush_emit |-> (remain != '0) && (fill == '0))
    else $error("flush emits from an empty line");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.flush_done |=> (slh == SLH_W'(NO_HIT)) && (remain == '0))
    else $error("hit history not cleared after flush");

endmodule

FILE: rtl/windowed_threshold_zero_suppress.sv
// ----------------------------------------------------------------------------
// windowed_threshold_zero_suppress
// Zero suppression of an ADC sample frame around threshold hits.
// ----------------------------------------------------------------------------
// Samples stream in one per transaction, and a sample accepted on the input
// can be taken every clock while a frame runs and the output register has
// room. A sample is a hit when its signed code is at or below hit_threshold;
// sample i is passed on when any sample from i-20 through i+19 of the same
// frame is a hit. To see ahead, the block holds back 19 samples, so a kept
// sample leaves 19 transactions after it came in, with its frame position.
// The transaction with tlast set (or the 16384th sample of a frame) closes
// the frame: the input then stalls while the line drains its kept samples in
// order, up to the first sample outside every window. The output register is
// the only coupling to a slow consumer: outside the drain the input is ready
// whenever that register is empty or being read in the same cycle. The
// threshold register may only be written while no frame is in progress.
// ----------------------------------------------------------------------------
module windowed_threshold_zero_suppress (
  input  logic                                clk,
  input  logic                                rst,
  // Threshold register write port.
  input  logic                                cfg_we,
  input  logic [wtzs_pkg::CODE_W-1:0]         cfg_wdata,
  // Sample input.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [wtzs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [13:0] sample_code
  input  logic                                s_axis_tlast,  // frame_end
  // Kept samples.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [wtzs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // [13:0] kept_sample,
                                                              // [27:14] sample_position
  output logic                                m_axis_tlast   // run_last
);
  import wtzs_pkg::*;

  wtzs_cmd_t                cmd;
  wtzs_stat_t               stat;
  logic signed [CODE_W-1:0] out_sample;
  logic [POS_W-1:0]         out_pos;

  // The controller decides when a sample is taken and steps the frame-end
  // drain; the datapath holds all the sample and position state.
  wtzs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  wtzs_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_sample  (s_axis_tdata[CODE_W-1:0]),
    .in_last    (s_axis_tlast),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_sample (out_sample),
    .out_pos    (out_pos),
    .out_last   (m_axis_tlast)
  );

  // Pack the result: sample code in the low bits, position above it, and
  // zeros up to the byte boundary.
  assign m_axis_tdata = {{(OUT_TDATA_W - CODE_W - POS_W){1'b0}}, out_pos, out_sample};

endmodule

FILE: tb/sv/windowed_threshold_zero_suppress_tb.sv
// ----------------------------------------------------------------------------
// windowed_threshold_zero_suppress_tb
// Self-checking bench for the windowed threshold zero-suppression block.
// ----------------------------------------------------------------------------
// A short table of hand-picked frames runs first; a few single-sample frames
// carry their result typed in, the rest is checked against an in-bench model
// of the hit window. Random frames follow under several thresholds. The
// sender works in bursts and the receiver stalls on its own pattern, with
// one long hold-off.
// ----------------------------------------------------------------------------
module windowed_threshold_zero_suppress_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wtzs_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 40;   // wait that covers a frame-end drain
  localparam int MAX_REPORTS  = 10;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 14;
  localparam int DIR_ROWS     = 27;

  typedef enum {ROW_SAMPLE, ROW_THRESHOLD} row_kind_t;
  // How a sample row is checked: by the model, by no result at all, or by the
  // row's own sample coming back at position 0 as the last result.
  typedef enum {CHK_PREDICT, CHK_NOTHING, CHK_ITSELF} row_check_t;

  typedef struct {
    row_kind_t  kind;
    int         value;
    bit         last;
    row_check_t check;
  } dir_row_t;

  typedef struct packed {
    logic signed [CODE_W-1:0] code;
    logic [POS_W-1:0]         pos;
    logic                     last;
  } kept_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CODE_W-1:0]      cfg_wdata;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [13:0] sample_code
  logic                   s_axis_tlast;   // frame_end
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [13:0] kept_sample, [27:14] sample_position
  logic                   m_axis_tlast;   // run_last

  windowed_threshold_zero_suppress u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Kept samples still owed by the block, oldest first.
  kept_t kept_due[$];
  int    mismatches = 0;
  int    kept_seen  = 0;
  int    burst_left = 0;

  // Model state: the held-back samples, the hit history and the frame index.
  logic signed [CODE_W-1:0] threshold = -14'sd8192;
  logic [CODE_W-1:0]        delay_line [0:HALF_WINDOW-1];
  int                       fill      = 0;
  int                       since_hit = NO_HIT;
  int                       frame_pos = 0;

  dir_row_t dir_table [DIR_ROWS];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Works out which waiting samples leave when one sample is taken, and
  // queues them with the last one marked.
  function automatic void predict_kept(input logic [CODE_W-1:0] code, input bit end_in);
    int  n0;
    int  cnt;
    int  age;
    bit  closes;
    n0 = kept_due.size();
    closes = end_in || (frame_pos >= FRAME_DEPTH - 1);
    if ($signed(code) <= threshold) since_hit = 0;
    else if (since_hit < NO_HIT) since_hit++;
    delay_line[fill] = code;
    cnt = fill + 1;
    if (closes) begin
      for (int k = 0; k < cnt; k++) begin
        age = cnt - 1 - k;
        if (since_hit <= age + HALF_WINDOW)
          kept_due.push_back('{delay_line[k], POS_W'(frame_pos - age), 1'b0});
      end
      fill = 0;
      since_hit = NO_HIT;
      frame_pos = 0;
    end else begin
      if (cnt > LINE_DEPTH) begin
        // The oldest sample now has its whole lookahead in view.
        if (since_hit <= LINE_DEPTH + HALF_WINDOW)
          kept_due.push_back('{delay_line[0], POS_W'(frame_pos - LINE_DEPTH), 1'b0});
        for (int k = 0; k < LINE_DEPTH; k++) delay_line[k] = delay_line[k + 1];
        fill = LINE_DEPTH;
      end else begin
        fill = cnt;
      end
      frame_pos++;
    end
    if (kept_due.size() > n0) kept_due[kept_due.size() - 1].last = 1'b1;
  endfunction

  // Offers one sample and returns at the edge that accepts it. Gaps fall
  // between bursts of random length.
  task automatic send_sample(input logic [CODE_W-1:0] code, input bit last,
                             input row_check_t check);
    int n0;
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W - CODE_W){1'b0}}, code};
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    n0 = kept_due.size();
    predict_kept(code, last);
    if (check != CHK_PREDICT) begin
      while (kept_due.size() > n0) void'(kept_due.pop_back());
      if (check == CHK_ITSELF) kept_due.push_back('{code, '0, 1'b1});
    end
  endtask

  // The threshold may only change between frames, so wait for every owed
  // result and then for a possible drain that emits nothing.
  task automatic write_threshold(input logic [CODE_W-1:0] value);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (kept_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    threshold = value;
    burst_left = 0;
  endtask

  // A code at or below the threshold when a hit is wanted, above it otherwise.
  function automatic logic [CODE_W-1:0] pick_code(input int thr, input bit hit);
    int v;
    if (hit || thr >= 8191) v = -8192 + int'($urandom_range(0, thr + 8192));
    else v = thr + 1 + int'($urandom_range(0, 8190 - thr));
    return CODE_W'(v);
  endfunction

  task automatic run_frame(input int thr, input int len);
    int               rate;
    bit               hit;
    logic [CODE_W-1:0] code;
    case ($urandom_range(0, 3))
      0:       rate = 0;
      1:       rate = 3;
      2:       rate = 8;
      default: rate = 40;
    endcase
    for (int i = 0; i < len; i++) begin
      hit = ($urandom_range(0, 99) < rate);
      if ($urandom_range(0, 9) == 0) code = CODE_W'($urandom);
      else code = pick_code(thr, hit);
      send_sample(code, i == len - 1, CHK_PREDICT);
    end
  endtask

  initial begin : stimulus
    int thr;
    int items;
    int len;
    int phase_thr [6];
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    for (int k = 0; k < HALF_WINDOW; k++) delay_line[k] = '0;

    dir_table = '{
      // Reset threshold is the most negative code: only that code is a hit.
      '{ROW_SAMPLE,    8191, 1'b1, CHK_NOTHING},
      '{ROW_SAMPLE,   -8192, 1'b1, CHK_ITSELF},
      // The most positive threshold makes every sample a hit.
      '{ROW_THRESHOLD, 8191, 1'b0, CHK_PREDICT},
      '{ROW_SAMPLE,    8191, 1'b1, CHK_ITSELF},
      '{ROW_THRESHOLD,    0, 1'b0, CHK_PREDICT},
      '{ROW_SAMPLE,       1, 1'b1, CHK_NOTHING},
      // 21-sample frame with one hit near its start: the first sample leaves
      // through the line, the other twenty in the frame-end drain.
      '{ROW_SAMPLE,       5, 1'b0, CHK_PREDICT},
      '{ROW_SAMPLE,      -1, 1'b0, CHK_PREDICT},
      '{ROW_SAMPLE,     120, 1'b0, CHK_PREDICT},
      '{ROW_SAMPLE,    8191, 1'b0, CHK_PREDICT},
      '{ROW_SAMPLE,     300, 1'b0, CHK_PREDICT},
      '{ROW_SAMPLE,       7, 1'b0, CHK_PREDICT},
      '{ROW_SAMPLE,    4096, 1'b0, CHK_PREDICT},
      '{ROW_SAMPLE,       1, 1'b0, CHK_PREDICT},
      '{ROW_SAMPLE,    2000, 1'b0, CHK_PREDICT},
      '{ROW_SAMPLE,    8000, 1'b0, CHK_PREDICT},
      '{ROW_SAMPLE,      64, 1'b0, CHK_PREDICT},
      '{ROW_SAMPLE,      15, 1'b0, CHK_PREDICT},
      '{ROW_SAMPLE,    3333, 1'b0, CHK_PREDICT},
      '{ROW_SAMPLE,     900, 1'b0, CHK_PREDICT},
      '{ROW_SAMPLE,       1, 1'b0, CHK_PREDICT},
      '{ROW_SAMPLE,    8191, 1'b0, CHK_PREDICT},
      '{ROW_SAMPLE,     250, 1'b0, CHK_PREDICT},
      '{ROW_SAMPLE,      42, 1'b0, CHK_PREDICT},
      '{ROW_SAMPLE,    6000, 1'b0, CHK_PREDICT},
      '{ROW_SAMPLE,      77, 1'b0, CHK_PREDICT},
      '{ROW_SAMPLE,     512, 1'b1, CHK_PREDICT}
    };

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    foreach (dir_table[r]) begin
      if (dir_table[r].kind == ROW_THRESHOLD)
        write_threshold(CODE_W'(dir_table[r].value));
      else
        send_sample(CODE_W'(dir_table[r].value), dir_table[r].last, dir_table[r].check);
    end

    // Random frames under both extreme thresholds, zero and random ones.
    phase_thr = '{-8192, 8191, 0, 0, 0, 0};
    for (int p = 3; p < 6; p++) phase_thr[p] = int'($urandom_range(0, 16383)) - 8192;
    foreach (phase_thr[p]) begin
      thr = phase_thr[p];
      write_threshold(CODE_W'(thr));
      items = 0;
      while (items < PHASE_ITEMS) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(46, 64) : $urandom_range(1, 45);
        run_frame(thr, len);
        items += len;
      end
    end

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (kept_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && kept_due.size() == 0)
      $display("windowed_threshold_zero_suppress_tb OK");
    else
      $display("windowed_threshold_zero_suppress_tb NOT OK");
    $finish;
  end

  // Receiver: stretches of always-ready, coin-flip and mostly-stalled, plus
  // one long hold-off once enough results have come while samples are still
  // offered, so the output register stays full and the input has to stall.
  initial begin : consumer
    int  stretch;
    int  mode;
    bit  held;
    m_axis_tready = 1'b0;
    stretch = 0;
    mode    = 0;
    held    = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && kept_seen >= 40 && s_axis_tvalid) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        if (stretch == 0) begin
          mode    = $urandom_range(0, 2);
          stretch = $urandom_range(16, 96);
        end
        stretch--;
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Each result transaction is matched against the oldest owed one.
  always @(posedge clk) begin : kept_checker
    kept_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      kept_seen++;
      if (kept_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: code %0d pos %0d last %0b",
                   $signed(m_axis_tdata[CODE_W-1:0]),
                   m_axis_tdata[CODE_W+POS_W-1:CODE_W], m_axis_tlast);
      end else begin
        want = kept_due.pop_front();
        if (m_axis_tdata[CODE_W-1:0] !== want.code ||
            m_axis_tdata[CODE_W+POS_W-1:CODE_W] !== want.pos ||
            m_axis_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected code %0d pos %0d last %0b, got code %0d pos %0d last %0b",
                     want.code, want.pos, want.last,
                     $signed(m_axis_tdata[CODE_W-1:0]),
                     m_axis_tdata[CODE_W+POS_W-1:CODE_W], m_axis_tlast);
        end
      end
    end
  end

  initial begin : watchdog
    int cycles;
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
    $display("timeout after %0d cycles", cycles);
    $display("windowed_threshold_zero_suppress_tb NOT OK");
    $finish;
  end

endmodule

FILE: windowed_threshold_zero_suppress.f
rtl/wtzs_pkg.sv
rtl/wtzs_ctrl.sv
rtl/wtzs_datapath.sv
rtl/windowed_threshold_zero_suppress.sv
tb/sv/windowed_threshold_zero_suppress_tb.sv
